>>> design/pnm_ascii_pixel_decoder_core_defines.svh
// Assertion macros shared by the decoder RTL.
// Each expects clk and arst_n in scope.
`ifndef PNM_ASCII_PIXEL_DECODER_CORE_DEFINES_SVH
`define PNM_ASCII_PIXEL_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PNMDEC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define PNMDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PNMDEC_ASSERT_SAME(lbl, ante, cons, msg)
`define PNMDEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/pnmdec_pkg.sv
`timescale 1ns / 1ps
package pnmdec_pkg;

	localparam int unsigned MAX_PIXELS = 1048576;
	localparam int unsigned CNT_W      = 21;
	localparam int unsigned IDX_W      = 20;
	localparam int unsigned VAL_W      = 16;
	localparam int unsigned GAIN_W     = 8;
	localparam int unsigned PIX_W      = 8;

	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PIXELS);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [PIX_W-1:0] PIX_FULL  = 8'd255;
	localparam logic [PIX_W-1:0] PIX_ZERO  = 8'd0;

	typedef enum logic [1:0] {
		TYPE_NONE   = 2'd0,
		TYPE_BITMAP = 2'd1,
		TYPE_GREY   = 2'd2,
		TYPE_COLOUR = 2'd3
	} image_type_t;

	typedef enum logic [1:0] {
		REG_IMAGE_TYPE  = 2'd0,
		REG_PIXEL_COUNT = 2'd1,
		REG_GAIN        = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_BITMAP = 3'd1,
		ST_OVER       = 3'd2,
		ST_SHORT      = 3'd3,
		ST_EXACT      = 3'd4
	} status_t;

	typedef struct packed {
		image_type_t       image_type;
		logic [CNT_W-1:0]  pixel_count;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	typedef struct packed {
		logic             write_valid;
		logic [IDX_W-1:0] pixel_index;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [2:0]       channel_mask;
		status_t          status;
	} res_t;

endpackage

>>> design/pnmdec_cfg.sv
`timescale 1ns / 1ps
module pnmdec_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [20:0]            cfg_data,
	output pnmdec_pkg::cfg_t       cfg
);
	import pnmdec_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_type  <= TYPE_BITMAP;
			cfg_q.pixel_count <= '0;
			cfg_q.gain        <= GAIN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_TYPE:  cfg_q.image_type  <= image_type_t'(cfg_data[1:0]);
				REG_PIXEL_COUNT: cfg_q.pixel_count <= cfg_data[CNT_W-1:0];
				REG_GAIN:        cfg_q.gain        <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/pnmdec_decode.sv
`timescale 1ns / 1ps
module pnmdec_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pnmdec_pkg::cfg_t     cfg,
	input  logic                 step,
	input  logic [15:0]          token_value,
	input  logic                 token_numeric,
	input  logic                 end_of_data,
	output pnmdec_pkg::res_t     res
);
	import pnmdec_pkg::*;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] counter_q;
	logic             error_q;

	logic [1:0]              phase_n;
	logic [CNT_W-1:0]        counter_n;
	logic                    error_n;
	logic [CNT_W-1:0]        count_eff;
	image_type_t             type_eff;
	logic [1:0]              phase_eff;
	logic [GAIN_W+VAL_W-1:0] prod;
	logic [PIX_W-1:0]        scaled;
	logic [CNT_W-1:0]        counter_inc;
	logic                    in_range;
	logic [PIX_W-1:0]        bit_pix;

	always_comb begin
		count_eff   = (cfg.pixel_count > CNT_LIMIT) ? CNT_LIMIT : cfg.pixel_count;
		type_eff    = (cfg.image_type == TYPE_NONE) ? TYPE_BITMAP : cfg.image_type;
		phase_eff   = (phase_q == 2'd3) ? 2'd0 : phase_q;
		prod        = cfg.gain * token_value;
		scaled      = (|prod[GAIN_W+VAL_W-1:PIX_W]) ? PIX_FULL : prod[PIX_W-1:0];
		counter_inc = (counter_q == CNT_MAX) ? counter_q : counter_q + CNT_W'(1);
		in_range    = counter_q < count_eff;
		bit_pix     = (token_value == '0) ? PIX_FULL : PIX_ZERO;

		res       = '0;
		res.status = ST_OK;
		phase_n   = phase_q;
		counter_n = counter_q;
		error_n   = error_q;

		if (end_of_data) begin
			if (error_q)
				res.status = ST_BAD_BITMAP;
			else if (counter_q > count_eff || (counter_q == count_eff && phase_eff != 2'd0))
				res.status = ST_OVER;
			else if (counter_q < count_eff)
				res.status = ST_SHORT;
			else
				res.status = ST_EXACT;
		end else if (error_q) begin
			res.status = ST_BAD_BITMAP;
		end else if (token_numeric) begin
			if (type_eff == TYPE_COLOUR) begin
				if (in_range) begin
					res.write_valid  = 1'b1;
					res.pixel_index  = counter_q[IDX_W-1:0];
					res.channel_mask = 3'b001 << phase_eff;
					case (phase_eff)
						2'd0:    res.red   = scaled;
						2'd1:    res.green = scaled;
						default: res.blue  = scaled;
					endcase
				end else begin
					res.status = ST_OVER;
				end
				if (phase_eff == 2'd2) begin
					phase_n   = 2'd0;
					counter_n = counter_inc;
				end else begin
					phase_n = phase_eff + 2'd1;
				end
			end else if (!in_range) begin
				res.status = ST_OVER;
				counter_n  = counter_inc;
			end else if (type_eff == TYPE_BITMAP) begin
				if (token_value <= VAL_W'(1)) begin
					res.write_valid  = 1'b1;
					res.pixel_index  = counter_q[IDX_W-1:0];
					res.red          = bit_pix;
					res.green        = bit_pix;
					res.blue         = bit_pix;
					res.channel_mask = 3'b111;
					counter_n        = counter_inc;
				end else begin
					error_n    = 1'b1;
					res.status = ST_BAD_BITMAP;
				end
			end else begin
				res.write_valid  = 1'b1;
				res.pixel_index  = counter_q[IDX_W-1:0];
				res.red          = scaled;
				res.green        = scaled;
				res.blue         = scaled;
				res.channel_mask = 3'b111;
				counter_n        = counter_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			counter_q <= '0;
			error_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			counter_q <= counter_n;
			error_q   <= error_n;
		end
	end

endmodule

>>> design/pnm_ascii_pixel_decoder_core.sv
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                          tuser          tlast
// s_*       in   token_value[15:0]                           token_numeric  end_of_data
// m_*       out  pixel_index, red, green, blue, mask, status write_valid    -
// cfg_*     in   write: cfg_we, cfg_index, cfg_data[20:0]
// One token per cycle while m_tready is high; a token passes the input register, then the result register.
// The pixel counter and phase update as a token moves from the input register to the result.
// m_tready low holds the result; the input register still takes one more beat.
// arst_n clears valids, counter, phase, error latch and config registers to reset values; data registers are not reset.
`include "pnm_ascii_pixel_decoder_core_defines.svh"
module pnm_ascii_pixel_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // token_value
	input  logic        s_tuser,   // token_numeric
	input  logic        s_tlast,   // end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // pixel_index, red, green, blue, channel_mask, status, zero pad
	output logic        m_tuser,   // write_valid
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);
	import pnmdec_pkg::*;

	cfg_t        cfg;
	res_t        res;
	res_t        res_q;
	logic        valid_s1;
	logic [15:0] value_s1;
	logic        numeric_s1;
	logic        eod_s1;
	logic        out_valid_q;
	logic        adv;
	logic        s_fire;

	pnmdec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pnmdec_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.step          (adv),
		.token_value   (value_s1),
		.token_numeric (numeric_s1),
		.end_of_data   (eod_s1),
		.res           (res)
	);

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= s_fire || (valid_s1 && !adv);
			out_valid_q <= adv || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			value_s1   <= s_tdata;
			numeric_s1 <= s_tuser;
			eod_s1     <= s_tlast;
		end
		if (adv)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.write_valid;
	assign m_tdata  = {6'd0, res_q.status, res_q.channel_mask, res_q.blue, res_q.green,
		res_q.red, res_q.pixel_index};

	`PNMDEC_ASSERT_NEXT(a_adv_gives_result, adv, m_tvalid, "result register not loaded")
	`PNMDEC_ASSERT_SAME(a_nowrite_clean, m_tvalid && !res_q.write_valid, res_q.channel_mask == 3'd0 && res_q.pixel_index == '0, "no-write result carries data")
	`PNMDEC_ASSERT_SAME(a_mask_shape, m_tvalid && res_q.write_valid, $onehot(res_q.channel_mask) || res_q.channel_mask == 3'b111, "bad channel mask")
	`PNMDEC_ASSERT_SAME(a_write_ok_status, m_tvalid && res_q.write_valid, res_q.status == ST_OK, "write with non-ok status")

endmodule
